### src/swbm_pkg.sv
// Package for the sliding-window bandwidth meter.
// Holds operation codes, register indexes, timing constants and divide-by-constant factors.
// No dependencies.
package swbm_pkg;

   // Operation codes on req_func
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_LIMIT = 2'd1;
   localparam logic [1:0] FUNC_USAGE = 2'd2;

   // Register indexes on the csr port
   localparam logic CSR_RATE  = 1'b0;
   localparam logic CSR_SCALE = 1'b1;

   localparam logic [6:0] SCALE_FULL  = 7'd100;
   localparam logic [6:0] SCALE_RESET = 7'd101;

   // Timing in milliseconds
   localparam int unsigned MIN_SLOT_MS = 100;
   localparam int unsigned SECOND_MS   = 1000;
   localparam int unsigned PERIOD_MS   = 6000;
   localparam int unsigned AVG_DIV     = PERIOD_MS / SECOND_MS;

   localparam logic [31:0] MIN_SLOT_W = 32'(MIN_SLOT_MS);
   localparam logic [31:0] SECOND_W   = 32'(SECOND_MS);
   localparam logic [31:0] PERIOD_W   = 32'(PERIOD_MS);

   // floor(x / d) = (x * ceil(2^s / d)) >> s with s = 32 + clog2(d), exact for 32-bit x
   localparam int unsigned DIV100_SH  = 32 + $clog2(100);
   localparam logic [32:0] DIV100_MUL =
      33'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
   localparam int unsigned DIV1000_SH  = 32 + $clog2(1000);
   localparam logic [32:0] DIV1000_MUL =
      33'(((64'd1 << DIV1000_SH) + 64'd999) / 64'd1000);
   localparam int unsigned DIVAVG_SH  = 32 + $clog2(AVG_DIV);
   localparam logic [32:0] DIVAVG_MUL =
      33'(((64'd1 << DIVAVG_SH) + 64'(AVG_DIV) - 64'd1) / 64'(AVG_DIV));

endpackage

### src/sliding_window_bandwidth_meter.sv
// Top level of the sliding-window bandwidth meter: slot ring memory, walk sequencer,
// shared multiplier and result register.
// Depends on swbm_pkg.
//
// The meter keeps a ring of SLOTS time-stamped byte counters. An add item (func 0)
// merges its bytes into the newest slot if that slot was opened less than 100 ms
// ago, else it opens the next slot. An allowance item (func 1) sums the bytes of
// slots newer than one second back (900 ms in max mode), subtracts them from the
// scaled rate and, in max mode, caps the result by the scaled rate times the ms
// since the last allowance item, divided by 1000. With limiting off (rate 0 or
// scale above 100) it gives all-ones with rsp_unlimited set. A usage item (func 2)
// gives the average bytes per second over the last six seconds. The walk reads one
// ring entry per cycle from the slot memory, save for a bubble at the jump to the
// current slot, and every scale and divide uses one shared 33x32 multiplier,
// one product per cycle. req_ready is high only while no item is in work; a
// finished result waits in the output register and does not hold off the next
// item, which waits in S_DONE until the register drains. Slot valid bits clear at
// reset, so there is no clearing pass. All sums and time compares are plain
// 32-bit wrapping arithmetic. Write csr registers only while the block is idle.
module sliding_window_bandwidth_meter
   import swbm_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_byte_count,
   input  logic        req_max_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_amount,
   output logic        rsp_unlimited,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_ADDW  = 4'd2;
   localparam logic [3:0] S_WALK  = 4'd3;
   localparam logic [3:0] S_LIM1  = 4'd4;
   localparam logic [3:0] S_LIM2  = 4'd5;
   localparam logic [3:0] S_LIM3  = 4'd6;
   localparam logic [3:0] S_LIM4  = 4'd7;
   localparam logic [3:0] S_LIM5  = 4'd8;
   localparam logic [3:0] S_LIM6  = 4'd9;
   localparam logic [3:0] S_AVG1  = 4'd10;
   localparam logic [3:0] S_AVG2  = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   // Control registers
   logic [3:0]    state_ff, state_in;
   logic [31:0]   rate_ff, rate_in;
   logic [6:0]    scale_ff, scale_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [31:0]   newest_ff, newest_in;
   logic [31:0]   last_lim_ff, last_lim_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SLOTS-1:0] vld_ff, vld_in;
   logic          pend_ff, pend_in;
   logic          adding_ff, adding_in;
   logic          t0_ff, t0_in;

   // Item and datapath registers
   logic [1:0]    func_ff, func_in;
   logic [31:0]   now_ff, now_in;
   logic [31:0]   bytes_ff, bytes_in;
   logic          maxm_ff, maxm_in;
   logic [31:0]   cutoff_ff, cutoff_in;
   logic [31:0]   sum_ff, sum_in;
   logic [31:0]   lim_ff, lim_in;
   logic [31:0]   left_ff, left_in;
   logic [IW-1:0] issue_ff, issue_in;
   logic [IW-1:0] eval_ff, eval_in;
   logic [31:0]   res_amt_ff, res_amt_in;
   logic          res_unl_ff, res_unl_in;
   logic [31:0]   rsp_amt_ff, rsp_amt_in;
   logic          rsp_unl_ff, rsp_unl_in;
   logic [64:0]   prod_ff;

   // Slot memory
   logic [31:0]   time_mem  [SLOTS];
   logic [31:0]   bytes_mem [SLOTS];
   logic [31:0]   rd_time_ff, rd_bytes_ff;
   logic          rd_vld_ff;
   logic [IW-1:0] rd_addr;
   logic          mem_we;
   logic [IW-1:0] mem_addr;
   logic [31:0]   mem_time_wd, mem_bytes_wd;

   // Shared multiplier operands
   logic [32:0]   mul_a;
   logic [31:0]   mul_b;

   // Working values
   logic [31:0]   cut;
   logic [IW-1:0] next_slot;
   logic [31:0]   ent_time, ent_bytes;
   logic          ent_gt;
   logic          t0_now, add_now;
   logic [31:0]   lim_now, cap_now;

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_amount    = rsp_amt_ff;
   assign rsp_unlimited = rsp_unl_ff;

   assign next_slot = (cur_ff == LAST_IDX) ? '0 : cur_ff + 1'b1;
   // a slot never written reads as zero time and zero bytes
   assign ent_time  = rd_vld_ff ? rd_time_ff  : '0;
   assign ent_bytes = rd_vld_ff ? rd_bytes_ff : '0;
   assign ent_gt    = ent_time > cutoff_ff;
   assign t0_now    = (eval_ff == '0) ? ent_gt : t0_ff;
   assign add_now   = adding_ff | ent_gt;
   assign lim_now   = (scale_ff < SCALE_FULL) ? 32'(prod_ff >> DIV100_SH) : rate_ff;
   assign cap_now   = 32'(prod_ff >> DIV1000_SH);

   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      scale_in     = scale_ff;
      cur_in       = cur_ff;
      newest_in    = newest_ff;
      last_lim_in  = last_lim_ff;
      rsp_valid_in = rsp_valid_ff;
      vld_in       = vld_ff;
      pend_in      = pend_ff;
      adding_in    = adding_ff;
      t0_in        = t0_ff;
      func_in      = func_ff;
      now_in       = now_ff;
      bytes_in     = bytes_ff;
      maxm_in      = maxm_ff;
      cutoff_in    = cutoff_ff;
      sum_in       = sum_ff;
      lim_in       = lim_ff;
      left_in      = left_ff;
      issue_in     = issue_ff;
      eval_in      = eval_ff;
      res_amt_in   = res_amt_ff;
      res_unl_in   = res_unl_ff;
      rsp_amt_in   = rsp_amt_ff;
      rsp_unl_in   = rsp_unl_ff;
      rd_addr      = issue_ff;
      mem_we       = 1'b0;
      mem_addr     = cur_ff;
      mem_time_wd  = now_ff;
      mem_bytes_wd = bytes_ff;
      mul_a        = '0;
      mul_b        = '0;
      cut          = now_ff - SECOND_W;

      if (csr_write_en) begin
         case (csr_index)
            CSR_RATE:  rate_in  = csr_wdata;
            CSR_SCALE: scale_in = csr_wdata[6:0];
            default:   rate_in  = rate_ff;
         endcase
      end

      // result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               now_in   = req_now_ms;
               bytes_in = req_byte_count;
               maxm_in  = req_max_mode;
               state_in = S_START;
            end
         end

         S_START: begin
            sum_in     = '0;
            res_amt_in = '0;
            res_unl_in = 1'b0;
            adding_in  = 1'b0;
            pend_in    = 1'b1;
            case (func_ff)
               FUNC_ADD: begin
                  rd_addr = cur_ff;
                  if ((now_ff - newest_ff) < MIN_SLOT_W) begin
                     state_in = S_ADDW;
                  end else begin
                     mem_we       = 1'b1;
                     mem_addr     = next_slot;
                     vld_in[next_slot] = 1'b1;
                     cur_in       = next_slot;
                     newest_in    = now_ff;
                     state_in     = S_DONE;
                  end
               end
               FUNC_LIMIT: begin
                  cut = now_ff - SECOND_W + (maxm_ff ? MIN_SLOT_W : 32'd0);
                  cutoff_in = cut;
                  rd_addr   = LAST_IDX;
                  eval_in   = LAST_IDX;
                  issue_in  = LAST_IDX - 1'b1;
                  if (rate_ff == '0 || scale_ff > SCALE_FULL) begin
                     res_amt_in = '1;
                     res_unl_in = 1'b1;
                     state_in   = S_DONE;
                  end else if (newest_ff <= cut) begin
                     state_in = S_LIM1;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               FUNC_USAGE: begin
                  cut       = now_ff - PERIOD_W;
                  cutoff_in = cut;
                  rd_addr   = '0;
                  eval_in   = '0;
                  issue_in  = IW'(1);
                  state_in  = (newest_ff <= cut) ? S_AVG1 : S_WALK;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_ADDW: begin
            mem_we       = 1'b1;
            mem_addr     = cur_ff;
            mem_time_wd  = ent_time;
            mem_bytes_wd = ent_bytes + bytes_ff;
            vld_in[cur_ff] = 1'b1;
            state_in     = S_DONE;
         end

         S_WALK: begin
            if (!pend_ff) begin
               // bubble after a jump: the read of issue_ff lands next cycle
               pend_in  = 1'b1;
               eval_in  = issue_ff;
               issue_in = issue_ff - 1'b1;
            end else if (func_ff == FUNC_LIMIT) begin
               // newest-first walk from the ring end, jumping to the current slot
               if (ent_gt) begin
                  sum_in = sum_ff + ent_bytes;
                  if (eval_ff == '0) begin
                     state_in = S_LIM1;
                  end else begin
                     eval_in  = issue_ff;
                     issue_in = issue_ff - 1'b1;
                  end
               end else if (eval_ff > cur_ff) begin
                  pend_in  = 1'b0;
                  issue_in = cur_ff;
               end else begin
                  state_in = S_LIM1;
               end
            end else begin
               // oldest-first walk: skip stale entries, then take the rest;
               // the part past the current slot counts only if slot 0 is recent
               if (eval_ff == '0) begin
                  t0_in = ent_gt;
               end
               if (add_now) begin
                  sum_in = sum_ff + ent_bytes;
               end
               adding_in = add_now;
               eval_in   = issue_ff;
               issue_in  = issue_ff + 1'b1;
               if (eval_ff == cur_ff) begin
                  adding_in = 1'b0;
                  if (!t0_now) begin
                     state_in = S_AVG1;
                  end
               end
               if (eval_ff == LAST_IDX) begin
                  state_in = S_AVG1;
               end
            end
         end

         S_LIM1: begin
            mul_a    = 33'(rate_ff);
            mul_b    = 32'(scale_ff);
            state_in = S_LIM2;
         end

         S_LIM2: begin
            mul_a    = DIV100_MUL;
            mul_b    = prod_ff[31:0];
            state_in = S_LIM3;
         end

         S_LIM3: begin
            lim_in  = lim_now;
            left_in = (sum_ff >= lim_now) ? '0 : lim_now - sum_ff;
            if (maxm_ff) begin
               state_in = S_LIM4;
            end else begin
               res_amt_in  = (sum_ff >= lim_now) ? '0 : lim_now - sum_ff;
               last_lim_in = now_ff;
               state_in    = S_DONE;
            end
         end

         S_LIM4: begin
            mul_a    = 33'(lim_ff);
            mul_b    = now_ff - last_lim_ff;
            state_in = S_LIM5;
         end

         S_LIM5: begin
            mul_a    = DIV1000_MUL;
            mul_b    = prod_ff[31:0];
            state_in = S_LIM6;
         end

         S_LIM6: begin
            res_amt_in  = (cap_now < left_ff) ? cap_now : left_ff;
            last_lim_in = now_ff;
            state_in    = S_DONE;
         end

         S_AVG1: begin
            mul_a    = DIVAVG_MUL;
            mul_b    = sum_ff;
            state_in = S_AVG2;
         end

         S_AVG2: begin
            res_amt_in = 32'(prod_ff >> DIVAVG_SH);
            state_in   = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_amt_in   = res_amt_ff;
               rsp_unl_in   = res_unl_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= '0;
         scale_ff     <= SCALE_RESET;
         cur_ff       <= '0;
         newest_ff    <= '0;
         last_lim_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
         adding_ff    <= 1'b0;
         t0_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         scale_ff     <= scale_in;
         cur_ff       <= cur_in;
         newest_ff    <= newest_in;
         last_lim_ff  <= last_lim_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
         pend_ff      <= pend_in;
         adding_ff    <= adding_in;
         t0_ff        <= t0_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      now_ff     <= now_in;
      bytes_ff   <= bytes_in;
      maxm_ff    <= maxm_in;
      cutoff_ff  <= cutoff_in;
      sum_ff     <= sum_in;
      lim_ff     <= lim_in;
      left_ff    <= left_in;
      issue_ff   <= issue_in;
      eval_ff    <= eval_in;
      res_amt_ff <= res_amt_in;
      res_unl_ff <= res_unl_in;
      rsp_amt_ff <= rsp_amt_in;
      rsp_unl_ff <= rsp_unl_in;
      prod_ff    <= 65'(mul_a) * 65'(mul_b);
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[mem_addr]  <= mem_time_wd;
         bytes_mem[mem_addr] <= mem_bytes_wd;
      end
      rd_time_ff  <= time_mem[rd_addr];
      rd_bytes_ff <= bytes_mem[rd_addr];
      rd_vld_ff   <= vld_ff[rd_addr];
   end

`ifndef SYNTH
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && pend_ff) |-> (eval_ff <= LAST_IDX))
      else $error("walk evaluates an entry outside the ring");

   a_unl_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_unl_ff) |-> (rsp_amt_ff == '1))
      else $error("unlimited result without all-ones amount");

   a_add_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && func_ff == FUNC_ADD) |-> vld_ff[cur_ff])
      else $error("current slot not marked written after an add");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result loaded outside the done state");
`endif

endmodule
